// File: hdl/dmwbc_pkg.sv
// ----------------------------------------------------------------------------
// dmwbc_pkg
// Shared constants, command codes and controller/datapath structs for the
// direct-mapped write-back cache unit.
// ----------------------------------------------------------------------------
package dmwbc_pkg;

    // Default geometry.
    localparam int unsigned LINES_DEF      = 256;
    localparam int unsigned MEM_WORDS_DEF  = 65536;
    localparam int unsigned WORDS_PER_LINE = 16;
    localparam int unsigned WSEL_W         = 4;

    // Access commands.
    localparam logic [2:0] CMD_LW  = 3'd0;
    localparam logic [2:0] CMD_LH  = 3'd1;
    localparam logic [2:0] CMD_LHU = 3'd2;
    localparam logic [2:0] CMD_LB  = 3'd3;
    localparam logic [2:0] CMD_LBU = 3'd4;
    localparam logic [2:0] CMD_SW  = 3'd5;
    localparam logic [2:0] CMD_SH  = 3'd6;
    localparam logic [2:0] CMD_SB  = 3'd7;

    // Result status codes.
    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_MISALIGN  = 2'd1;
    localparam logic [1:0] STS_OUT_RANGE = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_step;
        logic load_in;
        logic check;
        logic div;
        logic fix;
        logic cmp;
        logic wb;
        logic rf;
        logic exec;
        logic push;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_done;
        logic err;
        logic hit;
        logic victim;
        logic cnt_done;
        logic out_free;
    } t_dp_sts;

endpackage

// File: hdl/dmwbc_ram.sv
// ----------------------------------------------------------------------------
// dmwbc_ram
// Generic RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module dmwbc_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 256,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/dmwbc_ctrl.sv
// ----------------------------------------------------------------------------
// dmwbc_ctrl
// Controller state machine: sequences memory clear, decode, tag lookup,
// write-back, refill, access and result hand-off.
// ----------------------------------------------------------------------------
module dmwbc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  dmwbc_pkg::t_dp_sts i_sts,
    output dmwbc_pkg::t_dp_cmd o_cmd
);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_CHECK = 4'd2;
    localparam logic [3:0] S_DIV   = 4'd3;
    localparam logic [3:0] S_FIX   = 4'd4;
    localparam logic [3:0] S_TAG   = 4'd5;
    localparam logic [3:0] S_CMP   = 4'd6;
    localparam logic [3:0] S_WB    = 4'd7;
    localparam logic [3:0] S_RF    = 4'd8;
    localparam logic [3:0] S_RD    = 4'd9;
    localparam logic [3:0] S_EXEC  = 4'd10;
    localparam logic [3:0] S_DONE  = 4'd11;

    logic [3:0] r_state;
    logic [3:0] n_state;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (i_sts.clr_done) n_state = S_IDLE;
            S_IDLE:  if (i_in_valid) n_state = S_CHECK;
            S_CHECK: n_state = i_sts.err ? S_DONE : S_DIV;
            S_DIV:   n_state = S_FIX;
            S_FIX:   n_state = S_TAG;
            S_TAG:   n_state = S_CMP;
            S_CMP: begin
                if (i_sts.hit) begin
                    n_state = S_RD;
                end else if (i_sts.victim) begin
                    n_state = S_WB;
                end else begin
                    n_state = S_RF;
                end
            end
            S_WB:    if (i_sts.cnt_done) n_state = S_RF;
            S_RF:    if (i_sts.cnt_done) n_state = S_RD;
            S_RD:    n_state = S_EXEC;
            S_EXEC:  n_state = S_DONE;
            S_DONE:  if (i_sts.out_free) n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Commands decoded from the state.
    assign o_in_ready     = (r_state == S_IDLE);
    assign o_cmd.clr_step = (r_state == S_CLEAR);
    assign o_cmd.load_in  = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.check    = (r_state == S_CHECK);
    assign o_cmd.div      = (r_state == S_DIV);
    assign o_cmd.fix      = (r_state == S_FIX);
    assign o_cmd.cmp      = (r_state == S_CMP);
    assign o_cmd.wb       = (r_state == S_WB);
    assign o_cmd.rf       = (r_state == S_RF);
    assign o_cmd.exec     = (r_state == S_EXEC);
    assign o_cmd.push     = (r_state == S_DONE) && i_sts.out_free;

endmodule

// File: hdl/dmwbc_dp.sv
// ----------------------------------------------------------------------------
// dmwbc_dp
// Datapath: address decode, line/tag split, tag and data stores, main
// memory, write-back and refill engines, load/store merge, result register.
// ----------------------------------------------------------------------------
module dmwbc_dp #(
    parameter int unsigned LINES     = dmwbc_pkg::LINES_DEF,
    parameter int unsigned MEM_WORDS = dmwbc_pkg::MEM_WORDS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dmwbc_pkg::t_dp_cmd i_cmd,
    output dmwbc_pkg::t_dp_sts o_sts,
    input  logic [2:0]         i_cmd_code,
    input  logic [31:0]        i_base_addr,
    input  logic signed [15:0] i_offset,
    input  logic signed [31:0] i_store_data,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic signed [31:0] o_load_data,
    output logic [1:0]         o_status,
    output logic               o_was_hit
);

    localparam int unsigned NBLK   = (MEM_WORDS + dmwbc_pkg::WORDS_PER_LINE - 1)
                                     / dmwbc_pkg::WORDS_PER_LINE;
    localparam int unsigned BLK_W  = $clog2(NBLK);
    localparam int unsigned NTAG   = (NBLK + LINES - 1) / LINES;
    localparam int unsigned TAG_W  = (NTAG > 1) ? $clog2(NTAG) : 1;
    localparam int unsigned LINE_W = $clog2(LINES);
    localparam int unsigned MA_W   = $clog2(MEM_WORDS);
    localparam int unsigned IDX_W  = BLK_W + dmwbc_pkg::WSEL_W;
    localparam int unsigned LA_W   = LINE_W + dmwbc_pkg::WSEL_W;
    localparam logic [63:0] RECIP64 = 64'h1_0000_0000 / LINES;
    localparam logic [31:0] RECIP   = RECIP64[31:0];

    // Item registers.
    logic [2:0]        r_cmd;
    logic [31:0]       r_addr;
    logic [31:0]       r_sdata;
    logic [BLK_W+31:0] r_prod;
    logic [BLK_W-1:0]  r_q;
    logic [BLK_W-1:0]  r_rem;
    logic [LINE_W-1:0] r_line;
    logic [TAG_W-1:0]  r_tag;
    logic [BLK_W-1:0]  r_vblk;
    logic [LINES-1:0]  r_valid;
    logic [4:0]        r_cnt;
    logic              r_pv;
    logic [3:0]        r_pi;
    logic              r_pin;
    logic [MA_W-1:0]   r_clr;
    logic [31:0]       r_load;
    logic [1:0]        r_status;
    logic              r_hit;
    logic              r_ovalid;
    logic [31:0]       r_oload;
    logic [1:0]        r_ostat;
    logic              r_ohit;

    logic [31:0]       n_addr;
    logic [BLK_W-1:0]  blk;
    logic              oor;
    logic              mis;
    logic              err;
    logic [BLK_W-1:0]  quot;
    logic [BLK_W+8:0]  qm;
    logic [BLK_W:0]    rem_x;
    logic              need_fix;
    logic [TAG_W-1:0]  tag_rd;
    logic              hit;
    logic [BLK_W-1:0]  vblk;
    logic              step;
    logic [IDX_W-1:0]  rf_idx;
    logic [IDX_W-1:0]  wb_idx;
    logic              rf_in;
    logic              wb_in;
    logic [31:0]       line_rd;
    logic [31:0]       mem_rd;
    logic              line_we;
    logic [LA_W-1:0]   line_wa;
    logic [31:0]       line_wd;
    logic [LA_W-1:0]   line_ra;
    logic              mem_we;
    logic [MA_W-1:0]   mem_wa;
    logic [31:0]       mem_wd;
    logic              tag_we;
    logic [15:0]       half;
    logic [7:0]        byte_v;
    logic [31:0]       ld_val;
    logic [31:0]       st_val;
    logic              is_store;
    logic              out_free;

    // Address sum and checks.
    assign n_addr = i_base_addr + {{16{i_offset[15]}}, i_offset};
    assign blk    = r_addr[BLK_W+5:6];
    assign oor    = ({2'b00, r_addr[31:2]} >= 32'(MEM_WORDS));
    always_comb begin
        mis = 1'b0;
        case (r_cmd) inside
            dmwbc_pkg::CMD_LW, dmwbc_pkg::CMD_SW: mis = (r_addr[1:0] != 2'b00);
            dmwbc_pkg::CMD_LH, dmwbc_pkg::CMD_LHU, dmwbc_pkg::CMD_SH: mis = r_addr[0];
            default: mis = 1'b0;
        endcase
    end
    assign err = oor | mis;

    // Line and tag split by reciprocal multiply and one correction.
    assign quot     = r_prod[BLK_W+31:32];
    assign qm       = {9'd0, quot} * (BLK_W+9)'(LINES);
    assign rem_x    = {1'b0, r_rem};
    assign need_fix = (rem_x >= (BLK_W+1)'(LINES));

    // Tag compare and victim block.
    assign hit  = r_valid[r_line] && (tag_rd == r_tag);
    assign vblk = BLK_W'({{(BLK_W+9-TAG_W){1'b0}}, tag_rd} * (BLK_W+9)'(LINES))
                  + BLK_W'(r_line);

    // Write-back and refill word indexes.
    assign step   = (i_cmd.wb | i_cmd.rf) & ~r_cnt[4];
    assign rf_idx = {blk, r_cnt[3:0]};
    assign wb_idx = {r_vblk, r_pi};
    assign rf_in  = ({1'b0, rf_idx} < (IDX_W+1)'(MEM_WORDS));
    assign wb_in  = ({1'b0, wb_idx} < (IDX_W+1)'(MEM_WORDS));

    // Data store ports.
    assign line_ra = i_cmd.wb ? {r_line, r_cnt[3:0]} : {r_line, r_addr[5:2]};
    assign is_store = (r_cmd == dmwbc_pkg::CMD_SW) || (r_cmd == dmwbc_pkg::CMD_SH)
                      || (r_cmd == dmwbc_pkg::CMD_SB);
    always_comb begin
        if (i_cmd.rf) begin
            line_we = r_pv;
            line_wa = {r_line, r_pi};
            line_wd = r_pin ? mem_rd : 32'd0;
        end else begin
            line_we = i_cmd.exec & is_store;
            line_wa = {r_line, r_addr[5:2]};
            line_wd = st_val;
        end
    end

    // Main memory ports.
    always_comb begin
        if (i_cmd.clr_step) begin
            mem_we = 1'b1;
            mem_wa = r_clr;
            mem_wd = 32'd0;
        end else begin
            mem_we = i_cmd.wb & r_pv & wb_in;
            mem_wa = wb_idx[MA_W-1:0];
            mem_wd = line_rd;
        end
    end

    assign tag_we = i_cmd.rf & r_cnt[4];

    // Load extraction and store merge.
    assign half   = r_addr[1] ? line_rd[31:16] : line_rd[15:0];
    always_comb begin
        case (r_addr[1:0])
            2'd0:    byte_v = line_rd[7:0];
            2'd1:    byte_v = line_rd[15:8];
            2'd2:    byte_v = line_rd[23:16];
            default: byte_v = line_rd[31:24];
        endcase
    end
    always_comb begin
        ld_val = 32'd0;
        st_val = line_rd;
        case (r_cmd)
            dmwbc_pkg::CMD_LW:  ld_val = line_rd;
            dmwbc_pkg::CMD_LH:  ld_val = {{16{half[15]}}, half};
            dmwbc_pkg::CMD_LHU: ld_val = {16'd0, half};
            dmwbc_pkg::CMD_LB:  ld_val = {{24{byte_v[7]}}, byte_v};
            dmwbc_pkg::CMD_LBU: ld_val = {24'd0, byte_v};
            dmwbc_pkg::CMD_SW:  st_val = r_sdata;
            dmwbc_pkg::CMD_SH: begin
                if (r_addr[1]) begin
                    st_val = {r_sdata[15:0], line_rd[15:0]};
                end else begin
                    st_val = {line_rd[31:16], r_sdata[15:0]};
                end
            end
            default: begin
                case (r_addr[1:0])
                    2'd0:    st_val = {line_rd[31:8], r_sdata[7:0]};
                    2'd1:    st_val = {line_rd[31:16], r_sdata[7:0], line_rd[7:0]};
                    2'd2:    st_val = {line_rd[31:24], r_sdata[7:0], line_rd[15:0]};
                    default: st_val = {r_sdata[7:0], line_rd[23:0]};
                endcase
            end
        endcase
    end

    assign out_free = ~r_ovalid | i_out_ready;

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_cnt    <= 5'd0;
            r_pv     <= 1'b0;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.clr_step) begin
                r_clr <= r_clr + MA_W'(1);
            end
            if (i_cmd.cmp || ((i_cmd.wb || i_cmd.rf) && r_cnt[4])) begin
                r_cnt <= 5'd0;
            end else if (step) begin
                r_cnt <= r_cnt + 5'd1;
            end
            r_pv <= step;
            if (tag_we) begin
                r_valid[r_line] <= 1'b1;
            end
            if (i_cmd.push) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_cmd   <= i_cmd_code;
            r_addr  <= n_addr;
            r_sdata <= i_store_data;
        end
        if (i_cmd.check) begin
            r_prod   <= {32'd0, blk} * {{BLK_W{1'b0}}, RECIP};
            r_status <= oor ? dmwbc_pkg::STS_OUT_RANGE
                      : (mis ? dmwbc_pkg::STS_MISALIGN : dmwbc_pkg::STS_OK);
            r_load   <= 32'd0;
            r_hit    <= 1'b0;
        end
        if (i_cmd.div) begin
            r_q   <= quot;
            r_rem <= blk - qm[BLK_W-1:0];
        end
        if (i_cmd.fix) begin
            if (need_fix) begin
                r_line <= LINE_W'(r_rem - BLK_W'(LINES));
                r_tag  <= TAG_W'(r_q + BLK_W'(1));
            end else begin
                r_line <= LINE_W'(r_rem);
                r_tag  <= TAG_W'(r_q);
            end
        end
        if (i_cmd.cmp) begin
            r_hit  <= hit;
            r_vblk <= vblk;
        end
        if (step) begin
            r_pi  <= r_cnt[3:0];
            r_pin <= rf_in;
        end
        if (i_cmd.exec) begin
            r_load <= ld_val;
        end
        if (i_cmd.push) begin
            r_oload <= r_load;
            r_ostat <= r_status;
            r_ohit  <= r_hit;
        end
    end

    // Tag store.
    dmwbc_ram #(.WIDTH(TAG_W), .DEPTH(LINES)) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (tag_we),
        .i_waddr (r_line),
        .i_wdata (r_tag),
        .i_raddr (r_line),
        .o_rdata (tag_rd)
    );

    // Line data store.
    dmwbc_ram #(.WIDTH(32), .DEPTH(LINES * dmwbc_pkg::WORDS_PER_LINE)) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (line_we),
        .i_waddr (line_wa),
        .i_wdata (line_wd),
        .i_raddr (line_ra),
        .o_rdata (line_rd)
    );

    // Main memory.
    dmwbc_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_main_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_wa),
        .i_wdata (mem_wd),
        .i_raddr (rf_idx[MA_W-1:0]),
        .o_rdata (mem_rd)
    );

    // Status to the controller and result port.
    assign o_sts.clr_done = (r_clr == MA_W'(MEM_WORDS - 1));
    assign o_sts.err      = err;
    assign o_sts.hit      = hit;
    assign o_sts.victim   = r_valid[r_line];
    assign o_sts.cnt_done = r_cnt[4];
    assign o_sts.out_free = out_free;

    assign o_out_valid = r_ovalid;
    assign o_load_data = r_oload;
    assign o_status    = r_ostat;
    assign o_was_hit   = r_ohit;

endmodule

// File: hdl/direct_mapped_writeback_cache_unit.sv
// ----------------------------------------------------------------------------
// direct_mapped_writeback_cache_unit
// Direct-mapped write-allocate cache in front of an on-chip word memory.
//
//   Channel | Direction | Ports                       | Word contents
//   --------+-----------+-----------------------------+--------------------------
//   s       | in        | i_s_tvalid/o_s_tready/tdata | cmd, base, offset, data
//   m       | out       | o_m_tvalid/i_m_tready/tdata | load_data, status, hit
//
// A hit passes check, divide, fix, tag, compare, read and execute to reach
// the output register, and a failed access goes from check straight there;
// the next word is accepted once the controller is back in idle. A miss adds
// a refill, plus a write-back first when the victim line is valid; each
// walks one word per cycle through the memory port. After reset the main
// memory is cleared, one word per cycle; no word is accepted until then. The
// result sits in an output register, so the next word is accepted while it waits.
// ----------------------------------------------------------------------------
module direct_mapped_writeback_cache_unit #(
    parameter int unsigned LINES     = dmwbc_pkg::LINES_DEF,
    parameter int unsigned MEM_WORDS = dmwbc_pkg::MEM_WORDS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [87:0] i_s_tdata,  // cmd[2:0], base_addr[34:3], offset[50:35],
                                    // store_data[82:51], zero fill
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata   // load_data[31:0], status[33:32],
                                    // was_hit[34], zero fill
);

    dmwbc_pkg::t_dp_cmd cmd;
    dmwbc_pkg::t_dp_sts sts;
    logic signed [31:0] load_data;
    logic [1:0]         status;
    logic               was_hit;

    // Controller.
    dmwbc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Datapath.
    dmwbc_dp #(.LINES(LINES), .MEM_WORDS(MEM_WORDS)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_cmd_code   (i_s_tdata[2:0]),
        .i_base_addr  (i_s_tdata[34:3]),
        .i_offset     (i_s_tdata[50:35]),
        .i_store_data (i_s_tdata[82:51]),
        .i_out_ready  (i_m_tready),
        .o_out_valid  (o_m_tvalid),
        .o_load_data  (load_data),
        .o_status     (status),
        .o_was_hit    (was_hit)
    );

    // Result word packing.
    assign o_m_tdata = {5'd0, was_hit, status, load_data};

endmodule
